### rtl/core/interval_location_case_binning_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the interval/location binning block
// Shared property shorthands, clocked on i_clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef INTERVAL_LOCATION_CASE_BINNING_DEFINES_SVH
`define INTERVAL_LOCATION_CASE_BINNING_DEFINES_SVH

// same-cycle implication
`define ILCB_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ILCB_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/ilcb_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ilcb_pkg
// Types, codes and saturating helpers for the interval/location binning block.
// ---------------------------------------------------------------------------
package ilcb_pkg;

    typedef enum logic [2:0] {
        CMD_CLEAR  = 3'd0,
        CMD_ADD    = 3'd1,
        CMD_REMOVE = 3'd2,
        CMD_FINAL  = 3'd3,
        CMD_READ   = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_IGNORED    = 2'd1,
        ST_ZERO_TOTAL = 2'd2
    } t_status;

    // configuration register indexes
    localparam logic [1:0] CFG_INTERVALS = 2'd0;
    localparam logic [1:0] CFG_LOCATIONS = 2'd1;
    localparam logic [1:0] CFG_CALIBRATE = 2'd2;

    // bit steps of the scaling divide (96-bit dividend)
    localparam int DIV_STEPS = 96;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [3:0]  interval;
        logic [7:0]  location;
        logic [15:0] patients;
        logic [31:0] measure;
        logic        censored;
    } t_in_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [47:0] cell_measure;
        logic [31:0] cell_cases;
        logic [31:0] cell_censored;
        logic [31:0] total_cases;
        logic [47:0] total_measure;
    } t_out_rsp;

    typedef struct packed {
        logic [47:0] meas;
        logic [31:0] cases;
        logic [31:0] cens;
    } t_cell;

    typedef enum logic [3:0] {
        S_IDLE, S_CLR, S_CELL_RD, S_CELL_MOD, S_SC_RD, S_SC_START, S_SC_WAIT,
        S_CU_TOP, S_CU_TOPD, S_CU_RD, S_CU_WR, S_RESP
    } t_state;

    typedef enum logic [2:0] {
        SC_IDLE, SC_MUL_LO, SC_MUL_HI, SC_LOAD, SC_DIV, SC_DONE
    } t_sc_state;

    function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [47:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[48] ? '1 : s[47:0];
    endfunction

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? '1 : s[31:0];
    endfunction

    function automatic t_cell cell_sum(input t_cell a, input t_cell b);
        t_cell r;
        r.meas  = sat_add48(a.meas, b.meas);
        r.cases = sat_add32(a.cases, b.cases);
        r.cens  = sat_add32(a.cens, b.cens);
        return r;
    endfunction

endpackage

### rtl/core/ilcb_mem.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ilcb_mem
// Single-port grid RAM, one access per cycle, registered read data.
// ---------------------------------------------------------------------------
module ilcb_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic              i_re,
    input  logic [AW-1:0]     i_addr,
    input  ilcb_pkg::t_cell   i_wdata,
    output ilcb_pkg::t_cell   o_rdata
);
    import ilcb_pkg::*;

    t_cell r_mem [DEPTH];
    t_cell r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/ilcb_scale.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ilcb_scale
// Computes floor(m * c * 2^16 / d) saturated to 48 bits: two partial products
// (m[31:0] * c and m[47:32] * c), then a restoring divide one quotient bit per cycle.
// ---------------------------------------------------------------------------
module ilcb_scale (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [47:0] i_m,
    input  logic [31:0] i_c,
    input  logic [47:0] i_d,
    output logic        o_done,
    output logic [47:0] o_q
);
    import ilcb_pkg::*;

    t_sc_state r_sc_state, n_sc_state;
    logic [47:0] r_m;
    logic [31:0] r_c;
    logic [47:0] r_d;
    logic [63:0] r_plo;
    logic [47:0] r_phi;
    logic [95:0] r_dvd;
    logic [47:0] r_rem;
    logic [47:0] r_q;
    logic        r_ovf;
    logic [6:0]  r_cnt;

    logic [79:0] w_prod;
    logic [48:0] w_rem_sh;
    logic        w_ge;
    logic [48:0] w_rem_sub;

    // full product and one divide step
    assign w_prod    = {16'b0, r_plo} + {r_phi, 32'b0};
    assign w_rem_sh  = {r_rem, r_dvd[95]};
    assign w_ge      = (w_rem_sh >= {1'b0, r_d});
    assign w_rem_sub = w_rem_sh - {1'b0, r_d};

    // next state
    always_comb begin
        n_sc_state = r_sc_state;
        case (r_sc_state)
            SC_IDLE:   if (i_start) n_sc_state = SC_MUL_LO;
            SC_MUL_LO: n_sc_state = SC_MUL_HI;
            SC_MUL_HI: n_sc_state = SC_LOAD;
            SC_LOAD:   n_sc_state = SC_DIV;
            SC_DIV:    if (r_cnt == 7'(DIV_STEPS - 1)) n_sc_state = SC_DONE;
            SC_DONE:   n_sc_state = SC_IDLE;
            default:   n_sc_state = SC_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_done = (r_sc_state == SC_DONE);
        o_q    = r_ovf ? '1 : r_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc_state <= SC_IDLE;
        end else begin
            r_sc_state <= n_sc_state;
        end
        case (r_sc_state)
            SC_IDLE: begin
                if (i_start) begin
                    r_m <= i_m;
                    r_c <= i_c;
                    r_d <= i_d;
                end
            end
            SC_MUL_LO: r_plo <= 64'(r_m[31:0]) * 64'(r_c);
            SC_MUL_HI: r_phi <= 48'(r_m[47:32]) * 48'(r_c);
            SC_LOAD: begin
                r_dvd <= {w_prod, 16'b0};
                r_rem <= '0;
                r_q   <= '0;
                r_ovf <= 1'b0;
                r_cnt <= '0;
            end
            SC_DIV: begin
                r_dvd <= {r_dvd[94:0], 1'b0};
                r_rem <= w_ge ? w_rem_sub[47:0] : w_rem_sh[47:0];
                r_q   <= {r_q[46:0], w_ge};
                r_ovf <= r_ovf | r_q[47];
                r_cnt <= r_cnt + 7'd1;
            end
            default: ;
        endcase
    end

endmodule

### rtl/core/interval_location_case_binning.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// interval_location_case_binning
// Interval-by-location grid of summed measure, case and censored counts
// with running totals; clear, add, remove, finalize and read commands.
// ---------------------------------------------------------------------------
//  channel   | signals                          | moves
//  ----------+----------------------------------+---------------------------
//  input     | i_in_valid, o_in_stall, i_in_req | one command request
//  output    | o_out_valid, i_out_stall, o_out_rsp | one result per request
//  config    | i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data | reg write
//
// Add, remove and read of an in-range cell: one grid read, then a write-back (none for read).
// Clear: every grid entry is written to zero, one grid entry per cycle.
// Finalize: when calibrating, each grid entry is rescaled by the bit-serial
//   divider; then the intervals of each location are cumulated.
// After reset the grid is swept to zero with o_in_stall high; config writes
//   are taken at any time out of reset.
// A waiting result blocks only the next result, not the next request.
// ---------------------------------------------------------------------------
module interval_location_case_binning #(
    parameter int MAX_INTERVALS = 16,
    parameter int MAX_LOCATIONS = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ilcb_pkg::t_in_req   i_in_req,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ilcb_pkg::t_out_rsp  o_out_rsp,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [8:0]          i_cfg_data
);
    import ilcb_pkg::*;
    `include "interval_location_case_binning_defines.svh"

    localparam int DEPTH = MAX_INTERVALS * MAX_LOCATIONS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_state      r_state, n_state;
    t_in_req     r_req;
    t_cell       r_acc;
    t_cell       r_rsp_cell;
    logic [1:0]  r_rsp_status;
    t_out_rsp    r_out;
    logic        r_out_valid;
    logic [AW-1:0] r_k;
    logic [8:0]  r_loc;
    logic [4:0]  r_iv;
    logic [47:0] r_prod_add;
    logic [47:0] r_sum;
    logic [31:0] r_case_total;
    logic [47:0] r_meas_total;
    logic        r_final;
    logic        r_clr_resp;
    logic [4:0]  r_cfg_iv;
    logic [8:0]  r_cfg_loc;
    logic        r_cfg_cal;

    logic        w_mem_we, w_mem_re;
    logic [AW-1:0] w_mem_addr;
    t_cell       w_mem_wdata, w_rdata;
    logic        w_sc_start, w_sc_done;
    logic [47:0] w_sc_q;
    logic [4:0]  w_ni;
    logic [8:0]  w_nl;
    logic        w_in_range, w_cu_none, w_k_last, w_out_load, w_set_final;
    logic [1:0]  w_status;
    logic [AW-1:0] w_req_addr;
    t_cell       w_cell_new, w_cu_sum;
    logic [47:0] w_sum_nx;

    function automatic logic [AW-1:0] cell_addr(input logic [4:0] iv, input logic [8:0] loc);
        return AW'(32'(iv) * MAX_LOCATIONS + 32'(loc));
    endfunction

    // effective limits and decode
    assign w_ni = (32'(r_cfg_iv) > MAX_INTERVALS) ? 5'(MAX_INTERVALS) : r_cfg_iv;
    assign w_nl = (32'(r_cfg_loc) > MAX_LOCATIONS) ? 9'(MAX_LOCATIONS) : r_cfg_loc;
    assign w_in_range = ({1'b0, i_in_req.interval} < w_ni) && ({1'b0, i_in_req.location} < w_nl);
    assign w_cu_none  = (w_ni < 5'd2) || (w_nl == 9'd0);
    assign w_k_last   = (r_k == AW'(DEPTH - 1));
    assign w_out_load = !r_out_valid || !i_out_stall;
    assign w_req_addr = cell_addr({1'b0, r_req.interval}, {1'b0, r_req.location});
    assign w_cu_sum   = cell_sum(w_rdata, r_acc);
    assign w_sum_nx   = sat_add48(r_sum, w_sc_q);

    always_comb begin
        case (i_in_req.cmd)
            CMD_CLEAR:  w_status = ST_OK;
            CMD_ADD, CMD_REMOVE, CMD_READ: w_status = w_in_range ? ST_OK : ST_IGNORED;
            CMD_FINAL:  w_status = (!r_final && r_cfg_cal && r_meas_total == '0)
                                   ? ST_ZERO_TOTAL : ST_OK;
            default:    w_status = ST_IGNORED;
        endcase
    end

    // cell update for add / remove / read
    always_comb begin
        w_cell_new = w_rdata;
        case (r_req.cmd)
            CMD_ADD: begin
                w_cell_new.meas = sat_add48(w_rdata.meas, r_prod_add);
                if (r_req.censored) begin
                    w_cell_new.cens = sat_add32(w_rdata.cens, 32'(r_req.patients));
                end else begin
                    w_cell_new.cases = sat_add32(w_rdata.cases, 32'(r_req.patients));
                end
            end
            CMD_REMOVE: w_cell_new = '0;
            default: ;
        endcase
    end

    // next state
    always_comb begin
        n_state     = r_state;
        w_set_final = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_req.cmd)
                        CMD_CLEAR: n_state = S_CLR;
                        CMD_ADD, CMD_REMOVE, CMD_READ: begin
                            n_state = w_in_range ? S_CELL_RD : S_RESP;
                        end
                        CMD_FINAL: begin
                            if (r_final || (r_cfg_cal && r_meas_total == '0)) begin
                                n_state = S_RESP;
                            end else if (r_cfg_cal) begin
                                n_state = S_SC_RD;
                            end else if (w_cu_none) begin
                                n_state     = S_RESP;
                                w_set_final = 1'b1;
                            end else begin
                                n_state = S_CU_TOP;
                            end
                        end
                        default: n_state = S_RESP;
                    endcase
                end
            end
            S_CLR: if (w_k_last) n_state = r_clr_resp ? S_RESP : S_IDLE;
            S_CELL_RD:  n_state = S_CELL_MOD;
            S_CELL_MOD: n_state = S_RESP;
            S_SC_RD:    n_state = S_SC_START;
            S_SC_START: n_state = S_SC_WAIT;
            S_SC_WAIT: begin
                if (w_sc_done) begin
                    if (!w_k_last) begin
                        n_state = S_SC_RD;
                    end else if (w_cu_none) begin
                        n_state     = S_RESP;
                        w_set_final = 1'b1;
                    end else begin
                        n_state = S_CU_TOP;
                    end
                end
            end
            S_CU_TOP:  n_state = S_CU_TOPD;
            S_CU_TOPD: n_state = S_CU_RD;
            S_CU_RD:   n_state = S_CU_WR;
            S_CU_WR: begin
                if (r_iv != 5'd0) begin
                    n_state = S_CU_RD;
                end else if (10'(r_loc) + 10'd1 == 10'(w_nl)) begin
                    n_state     = S_RESP;
                    w_set_final = 1'b1;
                end else begin
                    n_state = S_CU_TOP;
                end
            end
            S_RESP:  if (w_out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs: grid port, scaler start, input stall
    always_comb begin
        w_mem_we    = 1'b0;
        w_mem_re    = 1'b0;
        w_mem_addr  = '0;
        w_mem_wdata = '0;
        w_sc_start  = 1'b0;
        o_in_stall  = (r_state != S_IDLE) || !i_rst_n;
        case (r_state)
            S_CLR: begin
                w_mem_we   = 1'b1;
                w_mem_addr = r_k;
            end
            S_CELL_RD: begin
                w_mem_re   = 1'b1;
                w_mem_addr = w_req_addr;
            end
            S_CELL_MOD: begin
                w_mem_we    = (r_req.cmd != CMD_READ);
                w_mem_addr  = w_req_addr;
                w_mem_wdata = w_cell_new;
            end
            S_SC_RD: begin
                w_mem_re   = 1'b1;
                w_mem_addr = r_k;
            end
            S_SC_START: w_sc_start = 1'b1;
            S_SC_WAIT: begin
                w_mem_we    = w_sc_done;
                w_mem_addr  = r_k;
                w_mem_wdata = {w_sc_q, r_acc.cases, r_acc.cens};
            end
            S_CU_TOP: begin
                w_mem_re   = 1'b1;
                w_mem_addr = cell_addr(w_ni - 5'd1, r_loc);
            end
            S_CU_RD: begin
                w_mem_re   = 1'b1;
                w_mem_addr = cell_addr(r_iv, r_loc);
            end
            S_CU_WR: begin
                w_mem_we    = 1'b1;
                w_mem_addr  = cell_addr(r_iv, r_loc);
                w_mem_wdata = w_cu_sum;
            end
            default: ;
        endcase
    end

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_k          <= '0;
            r_clr_resp   <= 1'b0;
            r_case_total <= '0;
            r_meas_total <= '0;
            r_final      <= 1'b0;
            r_out_valid  <= 1'b0;
            r_cfg_iv     <= 5'd16;
            r_cfg_loc    <= 9'd256;
            r_cfg_cal    <= 1'b1;
        end else begin
            r_state <= n_state;

            // config writes
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_INTERVALS: r_cfg_iv  <= i_cfg_data[4:0];
                    CFG_LOCATIONS: r_cfg_loc <= i_cfg_data;
                    CFG_CALIBRATE: r_cfg_cal <= i_cfg_data[0];
                    default: ;
                endcase
            end

            // result register
            if (r_state == S_RESP && w_out_load) begin
                r_out_valid <= 1'b1;
                r_out <= {r_rsp_status, r_rsp_cell.meas, r_rsp_cell.cases,
                          r_rsp_cell.cens, r_case_total, r_meas_total};
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_req        <= i_in_req;
                        r_rsp_cell   <= '0;
                        r_rsp_status <= w_status;
                        r_k          <= '0;
                        r_sum        <= '0;
                        r_loc        <= '0;
                        r_clr_resp   <= (i_in_req.cmd == CMD_CLEAR);
                    end
                end
                S_CLR: begin
                    r_k          <= r_k + AW'(1);
                    r_case_total <= '0;
                    r_meas_total <= '0;
                    r_final      <= 1'b0;
                end
                S_CELL_RD: r_prod_add <= 48'(r_req.patients) * 48'(r_req.measure);
                S_CELL_MOD: begin
                    r_rsp_cell <= w_cell_new;
                    case (r_req.cmd)
                        CMD_ADD: begin
                            r_meas_total <= sat_add48(r_meas_total, r_prod_add);
                            if (!r_req.censored) begin
                                r_case_total <= sat_add32(r_case_total, 32'(r_req.patients));
                            end
                        end
                        CMD_REMOVE: begin
                            r_case_total <= (r_case_total > w_rdata.cases)
                                            ? r_case_total - w_rdata.cases : '0;
                            r_meas_total <= (r_meas_total > w_rdata.meas)
                                            ? r_meas_total - w_rdata.meas : '0;
                        end
                        default: ;
                    endcase
                end
                S_SC_START: r_acc <= w_rdata;
                S_SC_WAIT: begin
                    if (w_sc_done) begin
                        r_sum <= w_sum_nx;
                        r_k   <= r_k + AW'(1);
                        if (w_k_last) begin
                            r_meas_total <= w_sum_nx;
                        end
                    end
                end
                S_CU_TOPD: begin
                    r_acc <= w_rdata;
                    r_iv  <= w_ni - 5'd2;
                end
                S_CU_WR: begin
                    r_acc <= w_cu_sum;
                    if (r_iv == 5'd0) begin
                        r_loc <= r_loc + 9'd1;
                    end else begin
                        r_iv <= r_iv - 5'd1;
                    end
                end
                default: ;
            endcase

            if (w_set_final) begin
                r_final <= 1'b1;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;
    assign o_cfg_ready = i_rst_n;

    // grid storage
    ilcb_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_re    (w_mem_re),
        .i_addr  (w_mem_addr),
        .i_wdata (w_mem_wdata),
        .o_rdata (w_rdata)
    );

    // calibration scaler
    ilcb_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sc_start),
        .i_m     (w_rdata.meas),
        .i_c     (r_case_total),
        .i_d     (r_meas_total),
        .o_done  (w_sc_done),
        .o_q     (w_sc_q)
    );

    // checks
    `ILCB_ASSERT_NXT(a_idle_totals, r_state == S_IDLE && !i_in_valid, $stable(r_case_total) && $stable(r_meas_total), "totals changed while idle")
    `ILCB_ASSERT_NXT(a_final_set, r_state == S_CU_WR && n_state == S_RESP, r_final, "finalize done without flag")
    `ILCB_ASSERT_NXT(a_rsp_totals, r_state == S_RESP && w_out_load, o_out_valid && o_out_rsp.total_cases == r_case_total && o_out_rsp.total_measure == r_meas_total, "result totals mismatch")

endmodule
